[src/emue_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emue_pkg
// Shared widths, constants and types for the multi-turn unwrap and filter.
// ----------------------------------------------------------------------------
package emue_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned SAMPLE_W     = 12;
  localparam int unsigned TICK_W       = 32;
  localparam int unsigned TURNS_W      = 20;
  localparam int unsigned DEG_W        = 29;
  localparam int unsigned FILTER_SHIFT = 3;
  localparam int unsigned SUM_W        = TICK_W + FILTER_SHIFT;
  localparam int unsigned TURN_SHIFT   = 12;
  localparam int unsigned DEG_COEF_W   = 10;
  localparam int unsigned PROD_W       = TICK_W + DEG_COEF_W;

  localparam logic [DEG_COEF_W-1:0] DEG_PER_TURN = DEG_COEF_W'(360);
  localparam logic [PROD_W-1:0]     ROUND_HALF   = PROD_W'(2048);
  localparam logic [TURN_SHIFT-1:0] TRUNC_BIAS   = TURN_SHIFT'(4095);

  typedef logic [BYTE_W-1:0]          byte_t;
  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [TICK_W-1:0]   tick_t;
  typedef logic signed [TURNS_W-1:0]  turns_t;
  typedef logic signed [DEG_W-1:0]    deg_t;

  typedef struct packed {
    sample_t raw;
    tick_t   filt;
  } filt_item_t;

endpackage
`default_nettype wire

[src/emue_capture.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emue_capture
// Input register: joins the two sensor bytes into one 12-bit sample.
// ----------------------------------------------------------------------------
module emue_capture (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire emue_pkg::byte_t in_angle_high_byte,
  input  wire emue_pkg::byte_t in_angle_low_byte,
  output logic                 smp_valid,
  input  wire logic            smp_ready,
  output emue_pkg::sample_t    smp_raw
);
  import emue_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  sample_t raw_r;
  logic    take;

  assign in_ready  = !valid_r || smp_ready;
  assign take      = in_valid && in_ready;
  assign valid_nxt = take ? 1'b1 : (valid_r && !smp_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // mask to 12 bits: upper nibble of the high byte is dropped
  always_ff @(posedge clk) begin
    if (take) begin
      raw_r <= {in_angle_high_byte[SAMPLE_W-BYTE_W-1:0], in_angle_low_byte};
    end
  end

  assign smp_valid = valid_r;
  assign smp_raw   = raw_r;

endmodule
`default_nettype wire

[src/emue_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emue_filter
// Unwraps the sample into a multi-turn tick count and applies the 7/8
// exponential filter; holds the running state.
// ----------------------------------------------------------------------------
module emue_filter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              smp_valid,
  output logic                   smp_ready,
  input  wire emue_pkg::sample_t smp_raw,
  output logic                   flt_valid,
  input  wire logic              flt_ready,
  output emue_pkg::filt_item_t   flt_item
);
  import emue_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  filt_item_t item_r;
  sample_t    prev_r;
  tick_t      tick_r;
  tick_t      filt_r;
  logic       first_r;

  logic             take;
  sample_t          prev_eff;
  tick_t            tick_base;
  tick_t            filt_base;
  sample_t          diff;
  tick_t            tick_nxt;
  logic [SUM_W-1:0] sum;
  tick_t            filt_nxt;

  assign smp_ready = !valid_r || flt_ready;
  assign take      = smp_valid && smp_ready;
  assign valid_nxt = take ? 1'b1 : (valid_r && !flt_ready);

  // first sample seeds the previous sample, tick count and filter
  always_comb begin
    prev_eff  = first_r ? smp_raw : prev_r;
    tick_base = first_r ? tick_t'({{(TICK_W-SAMPLE_W){1'b0}}, smp_raw}) : tick_r;
    filt_base = first_r ? tick_t'({{(TICK_W-SAMPLE_W){1'b0}}, smp_raw}) : filt_r;
    diff      = smp_raw - prev_eff;
    tick_nxt  = tick_base + tick_t'({{(TICK_W-SAMPLE_W){diff[SAMPLE_W-1]}}, diff});
    sum       = {filt_base, {FILTER_SHIFT{1'b0}}}
              - {{FILTER_SHIFT{filt_base[TICK_W-1]}}, filt_base}
              + {{FILTER_SHIFT{tick_nxt[TICK_W-1]}}, tick_nxt};
    filt_nxt  = tick_t'(sum[SUM_W-1:FILTER_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      first_r <= 1'b1;
      prev_r  <= '0;
      tick_r  <= '0;
      filt_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (take) begin
        first_r <= 1'b0;
        prev_r  <= smp_raw;
        tick_r  <= tick_nxt;
        filt_r  <= filt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.raw  <= smp_raw;
      item_r.filt <= filt_nxt;
    end
  end

  assign flt_valid = valid_r;
  assign flt_item  = item_r;

endmodule
`default_nettype wire

[src/emue_scale.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emue_scale
// Output register: scales the filtered ticks to whole turns and to degrees.
// ----------------------------------------------------------------------------
module emue_scale (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 flt_valid,
  output logic                      flt_ready,
  input  wire emue_pkg::filt_item_t flt_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output emue_pkg::sample_t         out_raw_angle,
  output emue_pkg::tick_t           out_filtered_ticks,
  output emue_pkg::turns_t          out_turns,
  output emue_pkg::deg_t            out_angle_degrees
);
  import emue_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  sample_t raw_r;
  tick_t   filt_r;
  turns_t  turns_r;
  deg_t    deg_r;

  logic                     take;
  logic                     neg;
  logic [TICK_W:0]          tsum;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        mag;
  logic [PROD_W-1:0]        rounded;
  deg_t                     deg_mag;
  turns_t                   turns_nxt;
  deg_t                     deg_nxt;

  assign flt_ready = !valid_r || out_ready;
  assign take      = flt_valid && flt_ready;
  assign valid_nxt = take ? 1'b1 : (valid_r && !out_ready);

  // turns truncate toward zero, degrees round half away from zero
  always_comb begin
    neg       = flt_item.filt[TICK_W-1];
    tsum      = {neg, flt_item.filt}
              + {{(TICK_W+1-TURN_SHIFT){1'b0}}, (neg ? TRUNC_BIAS : '0)};
    turns_nxt = turns_t'(tsum[TURN_SHIFT +: TURNS_W]);
    prod      = $signed({{(PROD_W-TICK_W){neg}}, flt_item.filt})
              * $signed({{(PROD_W-DEG_COEF_W){1'b0}}, DEG_PER_TURN});
    mag       = neg ? (-prod) : prod;
    rounded   = mag + ROUND_HALF;
    deg_mag   = deg_t'(rounded[TURN_SHIFT +: DEG_W]);
    deg_nxt   = neg ? (-deg_mag) : deg_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      raw_r   <= flt_item.raw;
      filt_r  <= flt_item.filt;
      turns_r <= turns_nxt;
      deg_r   <= deg_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_raw_angle      = raw_r;
  assign out_filtered_ticks = filt_r;
  assign out_turns          = turns_r;
  assign out_angle_degrees  = deg_r;

endmodule
`default_nettype wire

[src/encoder_multiturn_unwrap_ema_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_multiturn_unwrap_ema_unit
// Multi-turn unwrap of a 12-bit absolute angle sensor with a 7/8 filter.
//
// Input channel (in_valid/in_ready) carries the two sensor bytes of one
// sample; the result channel (out_valid/out_ready) returns the raw sample,
// the filtered tick position, whole turns and degrees for every item.
// An accepted item passes the input, filter and output registers in turn
// before its result is presented on the result channel.
// Throughput: one item per cycle while out_ready is held high; the tick
// count and filter state close their loop within the filter stage.
// Each stage takes a new item when empty or when its contents move on, so
// a result waiting at the output does not block the stages behind it
// until all three registers are full; then in_ready drops.
// Reset clears all valid flags and re-arms seeding: the first item after
// reset sets the tick count and filter to its own sample.
// ----------------------------------------------------------------------------
module encoder_multiturn_unwrap_ema_unit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire emue_pkg::byte_t in_angle_high_byte,
  input  wire emue_pkg::byte_t in_angle_low_byte,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output emue_pkg::sample_t    out_raw_angle,
  output emue_pkg::tick_t      out_filtered_ticks,
  output emue_pkg::turns_t     out_turns,
  output emue_pkg::deg_t       out_angle_degrees
);
  import emue_pkg::*;

  logic       smp_valid;
  logic       smp_ready;
  sample_t    smp_raw;
  logic       flt_valid;
  logic       flt_ready;
  filt_item_t flt_item;

  emue_capture u_capture (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_angle_high_byte (in_angle_high_byte),
    .in_angle_low_byte  (in_angle_low_byte),
    .smp_valid          (smp_valid),
    .smp_ready          (smp_ready),
    .smp_raw            (smp_raw)
  );

  emue_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp_raw   (smp_raw),
    .flt_valid (flt_valid),
    .flt_ready (flt_ready),
    .flt_item  (flt_item)
  );

  emue_scale u_scale (
    .clk                (clk),
    .rst_n              (rst_n),
    .flt_valid          (flt_valid),
    .flt_ready          (flt_ready),
    .flt_item           (flt_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_raw_angle      (out_raw_angle),
    .out_filtered_ticks (out_filtered_ticks),
    .out_turns          (out_turns),
    .out_angle_degrees  (out_angle_degrees)
  );

endmodule
`default_nettype wire

[src/emue_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emue_checker
// Port-level checks on the unwrap and filter block, bound to the top level.
// ----------------------------------------------------------------------------
module emue_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [11:0] out_raw_angle,
  input wire logic [31:0] out_filtered_ticks,
  input wire logic [19:0] out_turns,
  input wire logic [28:0] out_angle_degrees
);

  logic first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      first_r <= 1'b0;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_ticks)
      && $stable(out_angle_degrees))
    else $error("result changed while stalled");

  a_first_seed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r |-> out_filtered_ticks == {20'd0, out_raw_angle})
    else $error("first item after reset not seeded from its sample");

  a_turns_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_filtered_ticks[31] |-> out_turns == out_filtered_ticks[31:12])
    else $error("turns disagree with filtered ticks");

  a_deg_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_filtered_ticks[31] |-> out_angle_degrees[28]
      || out_angle_degrees == 29'd0)
    else $error("degrees sign disagrees with filtered ticks");

endmodule

bind encoder_multiturn_unwrap_ema_unit emue_checker u_emue_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_raw_angle      (out_raw_angle),
  .out_filtered_ticks (out_filtered_ticks),
  .out_turns          (out_turns),
  .out_angle_degrees  (out_angle_degrees)
);
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-turn unwrap and 7/8 filter unit. Angle
// samples are fed as byte pairs: first a handful of hand-picked cases, then
// random motion made of creeps, fast spins either way and arbitrary jumps.
// Every accepted item is run through an in-bench predictor, and each result
// is checked field by field against the oldest prediction. Both handshake
// sides idle at random, and the receiver also holds off long enough to back
// the pipeline up.
// ----------------------------------------------------------------------------
module tb_top;
  import emue_pkg::*;

  localparam int HALF_TURN_TICKS  = 2048;
  localparam int TICKS_PER_TURN   = 4096;
  localparam int DEGREES_PER_TURN = 360;
  localparam int FILTER_WEIGHT    = 7;

  typedef struct packed {
    sample_t raw;
    tick_t   filt;
    turns_t  turns;
    deg_t    deg;
  } position_t;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  byte_t   in_angle_high_byte;
  byte_t   in_angle_low_byte;
  logic    out_valid;
  logic    out_ready;
  sample_t out_raw_angle;
  tick_t   out_filtered_ticks;
  turns_t  out_turns;
  deg_t    out_angle_degrees;

  sample_t     last_sample;
  logic [31:0] tick_acc;
  tick_t       filt_pos;
  bit          seeding;

  position_t pending_positions[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_left     = 0;
  int        mismatches    = 0;

  encoder_multiturn_unwrap_ema_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_angle_high_byte (in_angle_high_byte),
    .in_angle_low_byte  (in_angle_low_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_raw_angle      (out_raw_angle),
    .out_filtered_ticks (out_filtered_ticks),
    .out_turns          (out_turns),
    .out_angle_degrees  (out_angle_degrees)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic position_t predict_position(byte_t hi, byte_t lo);
    position_t pos;
    sample_t   raw;
    sample_t   wrapped;
    int        delta;
    longint    sum;
    longint    scaled;
    raw = {hi[3:0], lo};
    if (seeding) begin
      last_sample = raw;
      tick_acc    = {20'd0, raw};
      filt_pos    = tick_t'({20'd0, raw});
      seeding     = 1'b0;
    end
    wrapped     = raw - last_sample + sample_t'(HALF_TURN_TICKS);
    delta       = int'(wrapped) - HALF_TURN_TICKS;
    last_sample = raw;
    tick_acc    = tick_acc + delta;
    sum         = longint'(filt_pos) * FILTER_WEIGHT + longint'(signed'(tick_acc));
    filt_pos    = tick_t'(sum >>> FILTER_SHIFT);
    scaled      = longint'(filt_pos) * DEGREES_PER_TURN;
    pos.raw     = raw;
    pos.filt    = filt_pos;
    pos.turns   = turns_t'(longint'(filt_pos) / TICKS_PER_TURN);
    if (scaled >= 0)
      pos.deg = deg_t'((scaled + HALF_TURN_TICKS) / TICKS_PER_TURN);
    else
      pos.deg = deg_t'((scaled - HALF_TURN_TICKS) / TICKS_PER_TURN);
    return pos;
  endfunction

  function automatic void check_field(string what, logic [31:0] expd, logic [31:0] got);
    if (expd !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %h got %h", $realtime, what, expd, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    position_t exp_pos;
    if (rst_n && out_valid && out_ready) begin
      if (pending_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no item outstanding, raw %h", $realtime, out_raw_angle);
      end else begin
        exp_pos = pending_positions.pop_front();
        check_field("raw_angle", 32'(exp_pos.raw), 32'(out_raw_angle));
        check_field("filtered_ticks", exp_pos.filt, out_filtered_ticks);
        check_field("turns", 32'(exp_pos.turns), 32'(out_turns));
        check_field("angle_degrees", 32'(exp_pos.deg), 32'(out_angle_degrees));
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_sample(byte_t hi, byte_t lo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_angle_high_byte <= hi;
    in_angle_low_byte  <= lo;
    do @(posedge clk); while (!in_ready);
    pending_positions.push_back(predict_position(hi, lo));
    @(negedge clk);
  endtask

  // move the shaft by delta ticks from the last sample, junk in the upper nibble
  task automatic step_by(int delta);
    sample_t nxt;
    nxt = last_sample + sample_t'(delta);
    send_sample({4'($urandom_range(15)), nxt[11:8]}, nxt[7:0]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_positions.size() != 0) @(negedge clk);
  endtask

  task automatic test_first_sample_seed();
    send_sample(8'hF1, 8'h00);
    send_sample(8'h01, 8'h00);
    send_sample(8'h00, 8'h00);
  endtask

  task automatic test_wrap_edges();
    send_sample(8'hFF, 8'hFF);
    send_sample(8'h00, 8'h00);
    send_sample(8'h08, 8'h00);
    send_sample(8'h0F, 8'hFF);
    send_sample(8'h07, 8'hFF);
    send_sample(8'h0F, 8'hFF);
    send_sample(8'h80, 8'h00);
    send_sample(8'h55, 8'hAA);
    send_sample(8'hAA, 8'h55);
  endtask

  task automatic test_reverse_spin();
    repeat (4) step_by(-2047);
    step_by(-HALF_TURN_TICKS);
    step_by(2047);
  endtask

  task automatic test_backpressure_fill();
    hold_left = 64;
    repeat (24) step_by(int'($urandom_range(64)) - 32);
    wait_drained();
  endtask

  task automatic test_random_motion(int count);
    int mode;
    int seg_len;
    int done;
    done = 0;
    while (done < count) begin
      mode    = $urandom_range(3);
      seg_len = $urandom_range(40, 10);
      for (int k = 0; k < seg_len && done < count; k++) begin
        case (mode)
          0: step_by(int'($urandom_range(16)) - 8);
          1: step_by(int'($urandom_range(HALF_TURN_TICKS, 1500)));
          2: step_by(-int'($urandom_range(HALF_TURN_TICKS, 1500)));
          default: send_sample(byte_t'($urandom), byte_t'($urandom));
        endcase
        done++;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_angle_high_byte = '0;
    in_angle_low_byte  = '0;
    last_sample        = '0;
    tick_acc           = '0;
    filt_pos           = '0;
    seeding            = 1'b1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 80;
    test_first_sample_seed();
    test_wrap_edges();
    test_reverse_spin();
    test_backpressure_fill();
    test_random_motion(260);

    send_idle_pct = 80;
    recv_idle_pct = 33;
    test_random_motion(260);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_motion(260);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_positions.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
